/* src/mer_pkg.sv */
// Shared widths, codes and controller/datapath interface types of the ellipse rasterizer.
`default_nettype none

package mer_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 10;

  // Derived widths
  localparam int OUT_W   = COORD_BITS + 1;            // plotted coordinate
  localparam int SQ_W    = 2 * RADIUS_BITS;           // radius squared
  localparam int POS_Y_W = RADIUS_BITS + 1;           // y walks down to -1
  localparam int T_W     = RADIUS_BITS + 1;           // 2x+1 and |y-1|
  localparam int MUL_W   = 2 * T_W;                   // multiplier operand
  localparam int PROD_W  = 2 * MUL_W;                 // multiplier product
  localparam int DEC_W   = PROD_W + 4;                // decision term, signed
  localparam int STEP_W  = 3 * RADIUS_BITS + 4;       // 2*ry^2*x and 2*rx^2*y, signed
  localparam int PT_W    = ((COORD_BITS > T_W) ? COORD_BITS : T_W) + 1;

  localparam int IN_DATA_W  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

  localparam int N_POINTS = 4;
  localparam int K_W      = $clog2(N_POINTS);
  localparam logic [K_W-1:0] LAST_PT = K_W'(N_POINTS - 1);

  // Command codes carried in tuser of the input channel
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,      // latch center and radii, x=0, y=ry, dx=0
    OP_SQ_RX,      // prod = rx*rx
    OP_SQ_RY,      // rx2 = prod, prod = ry*ry
    OP_DY,         // ry2 = prod, prod = rx2*ry
    OP_INIT_A,     // dy = 2*prod, dec = 4*ry2
    OP_INIT_B,     // dec -= 4*prod
    OP_INIT_C,     // dec += rx2
    OP_MOVE,       // advance x and/or y with dx/dy
    OP_DEC_A,      // dec += 4*dx when x moved
    OP_DEC_B,      // dec -= 4*dy when y moved
    OP_DEC_C,      // dec += 4*ry2 (region 1) or 4*rx2 (region 2)
    OP_TX_SQ,      // prod = (2x+1)^2
    OP_TY_SQ,      // tmp = prod, prod = (y-1)^2
    OP_MUL_RY2,    // tmp = prod, prod = ry2*tmp
    OP_MUL_RX2,    // dec = prod, prod = rx2*tmp
    OP_ADD_TY,     // dec += 4*prod, prod = rx2*ry2
    OP_SUB_RR      // dec -= 4*prod
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   region2;
    logic   emit_load;
    logic   emit_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic dx_ge_dy;
    logic y_zero;
    logic y_neg;
    logic dec_neg;
    logic dec_pos;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/mer_dp.sv */
// Datapath of the ellipse rasterizer: walk registers, decision term and shared multiplier.
`default_nettype none

module mer_dp (
  input  logic                                   clk,
  input  mer_pkg::dp_cmd_t                       cmd,
  input  logic signed [mer_pkg::COORD_BITS-1:0]  start_cx,
  input  logic signed [mer_pkg::COORD_BITS-1:0]  start_cy,
  input  logic [mer_pkg::RADIUS_BITS-1:0]        start_rx,
  input  logic [mer_pkg::RADIUS_BITS-1:0]        start_ry,
  output mer_pkg::dp_stat_t                      stat,
  output logic [mer_pkg::RADIUS_BITS-1:0]        pos_x,
  output logic signed [mer_pkg::POS_Y_W-1:0]     pos_y,
  output logic signed [mer_pkg::COORD_BITS-1:0]  center_x,
  output logic signed [mer_pkg::COORD_BITS-1:0]  center_y
);
  import mer_pkg::*;

  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [RADIUS_BITS-1:0]       rxi_r, ryi_r;
  logic [SQ_W-1:0]              rx2_r, ry2_r;
  logic [RADIUS_BITS-1:0]       x_r;
  logic signed [POS_Y_W-1:0]    y_r;
  logic signed [STEP_W-1:0]     dx_r, dy_r;
  logic signed [DEC_W-1:0]      dec_r;
  logic [PROD_W-1:0]            prod_r;
  logic [MUL_W-1:0]             tmp_r;
  logic                         incx_r, decy_r;

  logic [MUL_W-1:0]          mul_a, mul_b;
  logic                      mul_en;
  logic [PROD_W-1:0]         mul_p;
  logic [T_W-1:0]            tx, aty;
  logic signed [POS_Y_W-1:0] ym1;
  logic                      incx, decy;
  logic [STEP_W-1:0]         dx_inc, dy_dec;
  logic [DEC_W-1:0]          dx4, dy4, prod_ext, prod4, rx2_ext, rx2_4, ry2_4;

  assign tx  = {x_r, 1'b1};
  assign ym1 = y_r - POS_Y_W'(1);
  assign aty = ym1[POS_Y_W-1] ? T_W'(-ym1) : T_W'(ym1);

  // Region 1 always moves x, region 2 always moves y
  assign incx = cmd.region2 ? !stat.dec_pos : 1'b1;
  assign decy = cmd.region2 ? 1'b1 : !stat.dec_neg;

  assign dx_inc   = {{(STEP_W-SQ_W-1){1'b0}}, ry2_r, 1'b0};
  assign dy_dec   = {{(STEP_W-SQ_W-1){1'b0}}, rx2_r, 1'b0};
  assign dx4      = {{(DEC_W-STEP_W-2){dx_r[STEP_W-1]}}, dx_r, 2'b00};
  assign dy4      = {{(DEC_W-STEP_W-2){dy_r[STEP_W-1]}}, dy_r, 2'b00};
  assign prod_ext = {{(DEC_W-PROD_W){1'b0}}, prod_r};
  assign prod4    = {{(DEC_W-PROD_W-2){1'b0}}, prod_r, 2'b00};
  assign rx2_ext  = {{(DEC_W-SQ_W){1'b0}}, rx2_r};
  assign rx2_4    = {{(DEC_W-SQ_W-2){1'b0}}, rx2_r, 2'b00};
  assign ry2_4    = {{(DEC_W-SQ_W-2){1'b0}}, ry2_r, 2'b00};

  // Operand select for the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_SQ_RX: begin
        mul_a = {{(MUL_W-RADIUS_BITS){1'b0}}, rxi_r};
        mul_b = {{(MUL_W-RADIUS_BITS){1'b0}}, rxi_r};
      end
      OP_SQ_RY: begin
        mul_a = {{(MUL_W-RADIUS_BITS){1'b0}}, ryi_r};
        mul_b = {{(MUL_W-RADIUS_BITS){1'b0}}, ryi_r};
      end
      OP_DY: begin
        mul_a = {{(MUL_W-SQ_W){1'b0}}, rx2_r};
        mul_b = {{(MUL_W-RADIUS_BITS){1'b0}}, ryi_r};
      end
      OP_TX_SQ: begin
        mul_a = {{(MUL_W-T_W){1'b0}}, tx};
        mul_b = {{(MUL_W-T_W){1'b0}}, tx};
      end
      OP_TY_SQ: begin
        mul_a = {{(MUL_W-T_W){1'b0}}, aty};
        mul_b = {{(MUL_W-T_W){1'b0}}, aty};
      end
      OP_MUL_RY2: begin
        mul_a = {{(MUL_W-SQ_W){1'b0}}, ry2_r};
        mul_b = tmp_r;
      end
      OP_MUL_RX2: begin
        mul_a = {{(MUL_W-SQ_W){1'b0}}, rx2_r};
        mul_b = tmp_r;
      end
      OP_ADD_TY: begin
        mul_a = {{(MUL_W-SQ_W){1'b0}}, rx2_r};
        mul_b = {{(MUL_W-SQ_W){1'b0}}, ry2_r};
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_p;
    end
    unique case (cmd.op)
      OP_START: begin
        cx_r  <= start_cx;
        cy_r  <= start_cy;
        rxi_r <= start_rx;
        ryi_r <= start_ry;
        x_r   <= '0;
        y_r   <= {1'b0, start_ry};
        dx_r  <= '0;
      end
      OP_SQ_RY: rx2_r <= prod_r[SQ_W-1:0];
      OP_DY:    ry2_r <= prod_r[SQ_W-1:0];
      OP_INIT_A: begin
        dy_r  <= {prod_r[STEP_W-2:0], 1'b0};
        dec_r <= ry2_4;
      end
      OP_INIT_B: dec_r <= dec_r - prod4;
      OP_INIT_C: dec_r <= dec_r + rx2_ext;
      OP_MOVE: begin
        incx_r <= incx;
        decy_r <= decy;
        if (incx) begin
          x_r  <= x_r + RADIUS_BITS'(1);
          dx_r <= dx_r + dx_inc;
        end
        if (decy) begin
          y_r  <= y_r - POS_Y_W'(1);
          dy_r <= dy_r - dy_dec;
        end
      end
      OP_DEC_A: begin
        if (incx_r) begin
          dec_r <= dec_r + dx4;
        end
      end
      OP_DEC_B: begin
        if (decy_r) begin
          dec_r <= dec_r - dy4;
        end
      end
      OP_DEC_C:   dec_r <= dec_r + (cmd.region2 ? rx2_4 : ry2_4);
      OP_TY_SQ:   tmp_r <= prod_r[MUL_W-1:0];
      OP_MUL_RY2: tmp_r <= prod_r[MUL_W-1:0];
      OP_MUL_RX2: dec_r <= prod_ext;
      OP_ADD_TY:  dec_r <= dec_r + prod4;
      OP_SUB_RR:  dec_r <= dec_r - prod4;
      default: ;
    endcase
  end

  assign stat.dx_ge_dy = (dx_r >= dy_r);
  assign stat.y_zero   = (y_r == '0);
  assign stat.y_neg    = y_r[POS_Y_W-1];
  assign stat.dec_neg  = dec_r[DEC_W-1];
  assign stat.dec_pos  = !dec_r[DEC_W-1] && (dec_r != '0);

  assign pos_x    = x_r;
  assign pos_y    = y_r;
  assign center_x = cx_r;
  assign center_y = cy_r;

endmodule

`default_nettype wire

/* src/mer_ctrl.sv */
// Controller of the ellipse rasterizer: command sequencing and region tracking.
`default_nettype none

module mer_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  input  logic              emit_free,
  input  mer_pkg::dp_stat_t stat,
  output logic              in_ready,
  output mer_pkg::dp_cmd_t  cmd
);
  import mer_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RX,
    ST_SQ_RY,
    ST_DY,
    ST_INIT_A,
    ST_INIT_B,
    ST_INIT_C,
    ST_DEC_A,
    ST_DEC_B,
    ST_DEC_C,
    ST_TX_SQ,
    ST_TY_SQ,
    ST_MUL_RY2,
    ST_MUL_RX2,
    ST_ADD_TY,
    ST_SUB_RR
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE) && emit_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cmd.op        = OP_NONE;
    cmd.region2   = (phase_r == PH_R2);
    cmd.emit_load = 1'b0;
    cmd.emit_fin  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_START) begin
            cmd.op    = OP_START;
            state_nxt = ST_SQ_RX;
          end else if (phase_r != PH_IDLE) begin
            // y leaves zero downward on this step: the ellipse ends
            cmd.op        = OP_MOVE;
            cmd.emit_load = 1'b1;
            cmd.emit_fin  = stat.y_zero && ((phase_r == PH_R2) || !stat.dec_neg);
            state_nxt     = ST_DEC_A;
          end
        end
      end
      ST_SQ_RX: begin
        cmd.op    = OP_SQ_RX;
        state_nxt = ST_SQ_RY;
      end
      ST_SQ_RY: begin
        cmd.op    = OP_SQ_RY;
        state_nxt = ST_DY;
      end
      ST_DY: begin
        cmd.op    = OP_DY;
        state_nxt = ST_INIT_A;
      end
      ST_INIT_A: begin
        cmd.op    = OP_INIT_A;
        state_nxt = ST_INIT_B;
      end
      ST_INIT_B: begin
        cmd.op    = OP_INIT_B;
        state_nxt = ST_INIT_C;
      end
      ST_INIT_C: begin
        cmd.op = OP_INIT_C;
        if (stat.dx_ge_dy) begin
          state_nxt = ST_TX_SQ;
        end else begin
          phase_nxt = PH_R1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DEC_A: begin
        cmd.op    = OP_DEC_A;
        state_nxt = ST_DEC_B;
      end
      ST_DEC_B: begin
        cmd.op    = OP_DEC_B;
        state_nxt = ST_DEC_C;
      end
      ST_DEC_C: begin
        cmd.op = OP_DEC_C;
        if ((phase_r == PH_R1) && stat.dx_ge_dy) begin
          state_nxt = ST_TX_SQ;
        end else begin
          if ((phase_r == PH_R2) && stat.y_neg) begin
            phase_nxt = PH_IDLE;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_TX_SQ: begin
        cmd.op    = OP_TX_SQ;
        state_nxt = ST_TY_SQ;
      end
      ST_TY_SQ: begin
        cmd.op    = OP_TY_SQ;
        state_nxt = ST_MUL_RY2;
      end
      ST_MUL_RY2: begin
        cmd.op    = OP_MUL_RY2;
        state_nxt = ST_MUL_RX2;
      end
      ST_MUL_RX2: begin
        cmd.op    = OP_MUL_RX2;
        state_nxt = ST_ADD_TY;
      end
      ST_ADD_TY: begin
        cmd.op    = OP_ADD_TY;
        state_nxt = ST_SUB_RR;
      end
      ST_SUB_RR: begin
        cmd.op    = OP_SUB_RR;
        phase_nxt = stat.y_neg ? PH_IDLE : PH_R2;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/mer_emit.sv */
// Point output register of the ellipse rasterizer: mirrors one position into four quadrants.
`default_nettype none

module mer_emit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic                                  fin,
  input  logic [mer_pkg::RADIUS_BITS-1:0]       pos_x,
  input  logic signed [mer_pkg::POS_Y_W-1:0]    pos_y,
  input  logic signed [mer_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [mer_pkg::COORD_BITS-1:0] center_y,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [mer_pkg::OUT_W-1:0]             point_x,
  output logic [mer_pkg::OUT_W-1:0]             point_y,
  output logic                                  last_pt,
  output logic                                  fin_pt,
  output logic                                  free
);
  import mer_pkg::*;

  logic                      valid_r;
  logic [K_W-1:0]            k_r;
  logic [OUT_W-1:0]          px_r, py_r;
  logic                      fin_r;
  logic [RADIUS_BITS-1:0]    sx_r;
  logic signed [POS_Y_W-1:0] sy_r;
  logic                      fire;
  logic [K_W-1:0]            k_next;

  function automatic logic [OUT_W-1:0] mirror(input logic signed [PT_W-1:0] c,
                                              input logic signed [PT_W-1:0] d,
                                              input logic neg);
    logic signed [PT_W-1:0] s;
    s = neg ? (c - d) : (c + d);
    return s[OUT_W-1:0];
  endfunction

  assign fire   = valid_r && out_ready;
  assign k_next = k_r + K_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      k_r     <= '0;
    end else if (fire) begin
      if (k_r == LAST_PT) begin
        valid_r <= 1'b0;
      end else begin
        k_r <= k_next;
      end
    end
  end

  // Order: (+x,+y) (-x,+y) (+x,-y) (-x,-y); bit 0 of the index negates x, bit 1 y
  always_ff @(posedge clk) begin
    if (load) begin
      sx_r  <= pos_x;
      sy_r  <= pos_y;
      fin_r <= fin;
      px_r  <= mirror(PT_W'(center_x), PT_W'(pos_x), 1'b0);
      py_r  <= mirror(PT_W'(center_y), PT_W'(pos_y), 1'b0);
    end else if (fire && (k_r != LAST_PT)) begin
      px_r <= mirror(PT_W'(center_x), PT_W'(sx_r), k_next[0]);
      py_r <= mirror(PT_W'(center_y), PT_W'(sy_r), k_next[1]);
    end
  end

  assign out_valid = valid_r;
  assign point_x   = px_r;
  assign point_y   = py_r;
  assign last_pt   = (k_r == LAST_PT);
  assign fin_pt    = fin_r;
  assign free      = !valid_r || ((k_r == LAST_PT) && out_ready);

endmodule

`default_nettype wire

/* src/midpoint_ellipse_rasterizer.sv */
// Top level of the midpoint ellipse rasterizer: stream ports, controller, datapath, point output.
`default_nettype none

// Walks one quadrant of an axis-aligned ellipse with the midpoint algorithm and emits
// each position mirrored into four points, in the order (xc+x,yc+y), (xc-x,yc+y),
// (xc+x,yc-y), (xc-x,yc-y); points on the axes come out twice as they fall. A start
// item (tuser 0) latches center and radii and gives no points; the next item is taken
// once the controller has squared the radii and set up the decision term, or, when a
// radius is zero and the walk opens in region 2, also recomputed it for region 2. A step
// item (tuser 1) gives four points, the fourth with tlast, and all four with tuser set on
// the ellipse's final step; a step with no walk in progress is taken and dropped. A step
// is paced by the single point output register, which hands out one point a cycle while
// the output is not stalled, as the controller runs the decision update on the datapath;
// the step that hands over from region 1 to region 2 goes on to recompute the region 2
// decision term in the shared multiplier. A stalled output holds the block: the next item
// is taken once the fourth point of a step leaves. Coordinates wrap to COORD_BITS+1 bits.
module midpoint_ellipse_rasterizer (
  input  logic                              clk,
  input  logic                              rst_n,
  // center_x, center_y, radius_x, radius_y, zero pad
  input  logic [mer_pkg::IN_DATA_W-1:0]     in_tdata,
  // command
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // point_x, point_y, zero pad
  output logic [mer_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  // final_step
  output logic                              out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready
);
  import mer_pkg::*;

  dp_cmd_t                    cmd;
  dp_stat_t                   stat;
  logic                       emit_free;
  logic signed [COORD_BITS-1:0] in_cx, in_cy;
  logic [RADIUS_BITS-1:0]     in_rx, in_ry;
  logic [RADIUS_BITS-1:0]     pos_x;
  logic signed [POS_Y_W-1:0]  pos_y;
  logic signed [COORD_BITS-1:0] center_x, center_y;
  logic [OUT_W-1:0]           point_x, point_y;

  // Unpack the input item, lowest field first
  assign in_cx = in_tdata[COORD_BITS-1:0];
  assign in_cy = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_rx = in_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
  assign in_ry = in_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_cmd    (in_tuser),
    .emit_free (emit_free),
    .stat      (stat),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  mer_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .start_cx (in_cx),
    .start_cy (in_cy),
    .start_rx (in_rx),
    .start_ry (in_ry),
    .stat     (stat),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .center_x (center_x),
    .center_y (center_y)
  );

  // Snapshot the position before the step update lands
  mer_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (cmd.emit_load),
    .fin       (cmd.emit_fin),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .point_x   (point_x),
    .point_y   (point_y),
    .last_pt   (out_tlast),
    .fin_pt    (out_tuser),
    .free      (emit_free)
  );

  assign out_tdata = OUT_DATA_W'({point_y, point_x});

endmodule

`default_nettype wire

/* src/mer_checker.sv */
// Port-level assertions of the ellipse rasterizer and their binding to the top level.
`default_nettype none

module mer_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [mer_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast,
  input logic                           out_tuser
);
  import mer_pkg::*;

  // A stalled point holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output point changed");

  // The four points of a step follow one another with one final flag
  a_step_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && (out_tuser == $past(out_tuser)))
    else $error("points of a step broken up");

  // A start gives no points
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_START) |=> !out_tvalid)
    else $error("start produced a point");

  // No item is taken while a step still has points to hand out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken during a step's points");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);

`default_nettype wire
